FILE: rtl/tit_pkg.sv
`default_nettype none

package tit_pkg;

	localparam int SUM_BITS_DEF = 24;

	localparam int ET_W       = 16;
	localparam int ETA_W      = 12;
	localparam int PHI_W      = 11;
	localparam int FRAC_W     = 9;
	localparam int OUT_W      = 24;
	localparam int REASON_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Coordinate differences, their squares and the squared distance.
	localparam int DIFF_W = ETA_W + 1;
	localparam int SQ_W   = 2 * DIFF_W - 1;
	localparam int D2_W   = SQ_W + 1;

	// Squared distance bounds in units of 2^-16, exact integer forms of
	// 100*d2 < 65536, 25*d2 < 65536 and 100*d2 < 9*65536.
	localparam logic [D2_W-1:0] CORE_LIMIT  = D2_W'(656);
	localparam logic [D2_W-1:0] RING1_LIMIT = D2_W'(2622);
	localparam logic [D2_W-1:0] RING2_LIMIT = D2_W'(5899);

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam int QUEUE_DEPTH = 4;

	localparam logic OP_SEED    = 1'b0;
	localparam logic OP_CLUSTER = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEED_ET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORE_FRAC  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RING1_FRAC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RING2_FRAC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_EM_SHARE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EM_SHARE   = 3'd5;

	typedef enum logic [1:0] {
		REGION_CORE,
		REGION_RING1,
		REGION_RING2,
		REGION_NONE
	} region_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_PASS,
		REASON_ET,
		REASON_CORE,
		REASON_RING1,
		REASON_RING2,
		REASON_EM
	} reason_t;

	typedef struct packed {
		logic              op;
		logic [ET_W-1:0]   et;
		region_t           region;
		logic [FRAC_W-1:0] em;
		logic              last;
	} qentry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
	} qstat_t;

	typedef struct packed {
		logic [ET_W-1:0]   min_seed_et;
		logic [FRAC_W-1:0] min_core_fraction;
		logic [FRAC_W-1:0] max_ring1_fraction;
		logic [FRAC_W-1:0] max_ring2_fraction;
		logic [FRAC_W-1:0] min_em_share;
		logic [FRAC_W-1:0] max_em_share;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/tit_front.sv
`default_nettype none

module tit_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         op,
	input  wire logic [tit_pkg::ET_W-1:0]     cluster_et,
	input  wire logic signed [tit_pkg::ETA_W-1:0] cluster_eta,
	input  wire logic signed [tit_pkg::PHI_W-1:0] cluster_phi,
	input  wire logic [tit_pkg::FRAC_W-1:0]   em_fraction,
	input  wire logic                         last,
	input  wire tit_pkg::qstat_t              qstat,
	output logic                              push,
	output tit_pkg::qentry_t                  push_entry
);
	import tit_pkg::*;

	logic fen;
	logic accept;

	logic signed [ETA_W-1:0] seed_eta_q;
	logic signed [PHI_W-1:0] seed_phi_q;

	logic signed [DIFF_W-1:0] de;
	logic signed [DIFF_W-1:0] dp;

	logic                     valid_s1;
	logic                     op_s1;
	logic [ET_W-1:0]          et_s1;
	logic [FRAC_W-1:0]        em_s1;
	logic                     last_s1;
	logic signed [DIFF_W-1:0] de_s1;
	logic signed [DIFF_W-1:0] dp_s1;

	logic signed [2*DIFF_W-1:0] sqe_full;
	logic signed [2*DIFF_W-1:0] sqp_full;

	logic              valid_s2;
	logic              op_s2;
	logic [ET_W-1:0]   et_s2;
	logic [FRAC_W-1:0] em_s2;
	logic              last_s2;
	logic [SQ_W-1:0]   sqe_s2;
	logic [SQ_W-1:0]   sqp_s2;

	logic [D2_W-1:0] d2;
	region_t         region;

	// The pipe holds as a whole while its head waits on a full queue.
	assign fen      = !(valid_s2 && qstat.full);
	assign in_stall = !fen;
	assign accept   = in_valid && fen;

	assign de = $signed({cluster_eta[ETA_W-1], cluster_eta})
		- $signed({seed_eta_q[ETA_W-1], seed_eta_q});
	assign dp = $signed({{(DIFF_W-PHI_W){cluster_phi[PHI_W-1]}}, cluster_phi})
		- $signed({{(DIFF_W-PHI_W){seed_phi_q[PHI_W-1]}}, seed_phi_q});

	assign sqe_full = de_s1 * de_s1;
	assign sqp_full = dp_s1 * dp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_eta_q <= '0;
			seed_phi_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else if (fen) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept && op == OP_SEED) begin
				seed_eta_q <= cluster_eta;
				seed_phi_q <= cluster_phi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			op_s1   <= op;
			et_s1   <= cluster_et;
			em_s1   <= em_fraction;
			last_s1 <= last;
			de_s1   <= de;
			dp_s1   <= dp;
			op_s2   <= op_s1;
			et_s2   <= et_s1;
			em_s2   <= em_s1;
			last_s2 <= last_s1;
			sqe_s2  <= sqe_full[SQ_W-1:0];
			sqp_s2  <= sqp_full[SQ_W-1:0];
		end
	end

	assign d2 = {1'b0, sqe_s2} + {1'b0, sqp_s2};

	always_comb begin
		if (d2 < CORE_LIMIT) begin
			region = REGION_CORE;
		end else if (d2 < RING1_LIMIT) begin
			region = REGION_RING1;
		end else if (d2 < RING2_LIMIT) begin
			region = REGION_RING2;
		end else begin
			region = REGION_NONE;
		end
	end

	assign push = valid_s2 && fen;

	always_comb begin
		push_entry.op     = op_s2;
		push_entry.et     = et_s2;
		push_entry.region = region;
		push_entry.em     = em_s2;
		push_entry.last   = last_s2;
	end

endmodule

`default_nettype wire

FILE: rtl/tit_queue.sv
`default_nettype none

module tit_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tit_pkg::qentry_t push_entry,
	input  wire logic             pop,
	output tit_pkg::qentry_t      pop_entry,
	output tit_pkg::qstat_t       qstat
);
	import tit_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qentry_t          entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	assign pop_entry   = entries_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

`default_nettype wire

FILE: rtl/tit_back.sv
`default_nettype none

module tit_back #(
	parameter int SUM_BITS = tit_pkg::SUM_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tit_pkg::cfg_t                cfg,
	input  wire tit_pkg::qstat_t              qstat,
	output logic                              pop,
	input  wire tit_pkg::qentry_t             pop_entry,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              passed,
	output logic [tit_pkg::REASON_W-1:0]      fail_reason,
	output logic [tit_pkg::OUT_W-1:0]         core_energy,
	output logic [tit_pkg::OUT_W-1:0]         ring1_energy,
	output logic [tit_pkg::OUT_W-1:0]         ring2_energy
);
	import tit_pkg::*;

	localparam int TOT_W  = SUM_BITS + 2;
	localparam int PROD_W = TOT_W + FRAC_W;

	function automatic logic [SUM_BITS-1:0] add_sat(input logic [SUM_BITS-1:0] acc,
		input logic [ET_W-1:0] et);
		logic [SUM_BITS:0] s;
		s = {1'b0, acc} + (SUM_BITS+1)'(et);
		return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
	endfunction

	logic en;

	logic [SUM_BITS-1:0] core_q, ring1_q, ring2_q;
	logic [ET_W-1:0]     seed_et_q;
	logic [FRAC_W-1:0]   seed_em_q;

	logic [SUM_BITS-1:0] nxt_core, nxt_ring1, nxt_ring2;
	logic [ET_W-1:0]     nxt_seed_et;
	logic [FRAC_W-1:0]   nxt_seed_em;

	logic                valid_s1;
	logic [SUM_BITS-1:0] core_s1, ring1_s1, ring2_s1;
	logic [ET_W-1:0]     seed_et_s1;
	logic [FRAC_W-1:0]   seed_em_s1;

	logic                valid_s2;
	logic [SUM_BITS-1:0] core_s2, ring1_s2, ring2_s2;
	logic [TOT_W-1:0]    total_s2;
	logic                et_fail_s2, em_fail_s2;

	logic                valid_s3;
	logic [SUM_BITS-1:0] core_s3, ring1_s3, ring2_s3;
	logic [PROD_W-1:0]   core_lim_s3, ring1_lim_s3, ring2_lim_s3;
	logic                zero_s3, et_fail_s3, em_fail_s3;

	reason_t reason;

	logic                out_valid_q;
	logic                passed_q;
	logic [REASON_W-1:0] fail_reason_q;
	logic [OUT_W-1:0]    core_energy_q, ring1_energy_q, ring2_energy_q;

	// Accumulation and the decision pipe move together; a held result
	// freezes both and lets the queue absorb the front.
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !qstat.empty;

	always_comb begin
		nxt_core    = core_q;
		nxt_ring1   = ring1_q;
		nxt_ring2   = ring2_q;
		nxt_seed_et = seed_et_q;
		nxt_seed_em = seed_em_q;
		if (pop_entry.op == OP_SEED) begin
			nxt_core    = '0;
			nxt_ring1   = '0;
			nxt_ring2   = '0;
			nxt_seed_et = pop_entry.et;
			nxt_seed_em = pop_entry.em;
		end else begin
			case (pop_entry.region)
				REGION_CORE:  nxt_core  = add_sat(core_q, pop_entry.et);
				REGION_RING1: nxt_ring1 = add_sat(ring1_q, pop_entry.et);
				REGION_RING2: nxt_ring2 = add_sat(ring2_q, pop_entry.et);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q      <= '0;
			ring1_q     <= '0;
			ring2_q     <= '0;
			seed_et_q   <= '0;
			seed_em_q   <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (pop) begin
				core_q    <= nxt_core;
				ring1_q   <= nxt_ring1;
				ring2_q   <= nxt_ring2;
				seed_et_q <= nxt_seed_et;
				seed_em_q <= nxt_seed_em;
			end
			valid_s1    <= pop && pop_entry.last;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Ratio cuts compare 256*part against fraction*total, skipped on zero total.
	always_comb begin
		if (et_fail_s3) begin
			reason = REASON_ET;
		end else if (!zero_s3 && PROD_W'({core_s3, 8'd0}) < core_lim_s3) begin
			reason = REASON_CORE;
		end else if (!zero_s3 && PROD_W'({ring1_s3, 8'd0}) > ring1_lim_s3) begin
			reason = REASON_RING1;
		end else if (!zero_s3 && PROD_W'({ring2_s3, 8'd0}) > ring2_lim_s3) begin
			reason = REASON_RING2;
		end else if (em_fail_s3) begin
			reason = REASON_EM;
		end else begin
			reason = REASON_PASS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			core_s1    <= nxt_core;
			ring1_s1   <= nxt_ring1;
			ring2_s1   <= nxt_ring2;
			seed_et_s1 <= nxt_seed_et;
			seed_em_s1 <= nxt_seed_em;

			core_s2    <= core_s1;
			ring1_s2   <= ring1_s1;
			ring2_s2   <= ring2_s1;
			total_s2   <= TOT_W'(core_s1) + TOT_W'(ring1_s1) + TOT_W'(ring2_s1);
			et_fail_s2 <= seed_et_s1 < cfg.min_seed_et;
			em_fail_s2 <= (seed_em_s1 < cfg.min_em_share) || (seed_em_s1 > cfg.max_em_share);

			core_s3      <= core_s2;
			ring1_s3     <= ring1_s2;
			ring2_s3     <= ring2_s2;
			core_lim_s3  <= PROD_W'(cfg.min_core_fraction) * PROD_W'(total_s2);
			ring1_lim_s3 <= PROD_W'(cfg.max_ring1_fraction) * PROD_W'(total_s2);
			ring2_lim_s3 <= PROD_W'(cfg.max_ring2_fraction) * PROD_W'(total_s2);
			zero_s3      <= (total_s2 == '0);
			et_fail_s3   <= et_fail_s2;
			em_fail_s3   <= em_fail_s2;

			passed_q       <= (reason == REASON_PASS);
			fail_reason_q  <= reason;
			core_energy_q  <= sat_out(core_s3);
			ring1_energy_q <= sat_out(ring1_s3);
			ring2_energy_q <= sat_out(ring2_s3);
		end
	end

	assign out_valid    = out_valid_q;
	assign passed       = passed_q;
	assign fail_reason  = fail_reason_q;
	assign core_energy  = core_energy_q;
	assign ring1_energy = ring1_energy_q;
	assign ring2_energy = ring2_energy_q;

endmodule

`default_nettype wire

FILE: rtl/tau_isolation_trigger_top.sv
// Tau ring-isolation trigger.
// Input channel (in_valid / in_stall): a seed item (op 0) latches the seed and
// clears the core, ring one and ring two sums; a cluster item (op 1) adds its
// Et to one of the sums by its squared eta-phi distance to the seed, or to no
// sum beyond ring two. An item with last set produces one result on the
// output channel (out_valid / out_stall): the pass flag, the first failing
// cut and the three sums. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); the user must change it only while no item is in
// flight; the block does not enforce this. Throughput is one item per cycle
// while nothing stalls. After the transfer of its last item, a result passes
// two front stages for the distance and the region, the 4-entry queue, then
// the accumulate stage, the total, the cross-multiplication and the output
// register. Reset clears the seed, the sums, the queue and all valid flags,
// and loads the register defaults. When the receiver stalls, the result
// holds and the back end freezes; the front keeps taking items until the
// queue and its two stages fill, then raises in_stall.
`default_nettype none

module tau_isolation_trigger_top #(
	parameter int SUM_BITS = tit_pkg::SUM_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tit_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             op,
	input  wire logic [tit_pkg::ET_W-1:0]         cluster_et,
	input  wire logic signed [tit_pkg::ETA_W-1:0] cluster_eta,
	input  wire logic signed [tit_pkg::PHI_W-1:0] cluster_phi,
	input  wire logic [tit_pkg::FRAC_W-1:0]       em_fraction,
	input  wire logic                             last,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  passed,
	output logic [tit_pkg::REASON_W-1:0]          fail_reason,
	output logic [tit_pkg::OUT_W-1:0]             core_energy,
	output logic [tit_pkg::OUT_W-1:0]             ring1_energy,
	output logic [tit_pkg::OUT_W-1:0]             ring2_energy
);
	import tit_pkg::*;

	cfg_t    cfg_q;
	qstat_t  qstat;
	logic    push;
	logic    pop;
	qentry_t push_entry;
	qentry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_seed_et        <= '0;
			cfg_q.min_core_fraction  <= '0;
			cfg_q.max_ring1_fraction <= FRAC_W'(256);
			cfg_q.max_ring2_fraction <= FRAC_W'(256);
			cfg_q.min_em_share       <= '0;
			cfg_q.max_em_share       <= FRAC_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_SEED_ET:    cfg_q.min_seed_et        <= cfg_data[ET_W-1:0];
				CFG_MIN_CORE_FRAC:  cfg_q.min_core_fraction  <= cfg_data[FRAC_W-1:0];
				CFG_MAX_RING1_FRAC: cfg_q.max_ring1_fraction <= cfg_data[FRAC_W-1:0];
				CFG_MAX_RING2_FRAC: cfg_q.max_ring2_fraction <= cfg_data[FRAC_W-1:0];
				CFG_MIN_EM_SHARE:   cfg_q.min_em_share       <= cfg_data[FRAC_W-1:0];
				CFG_MAX_EM_SHARE:   cfg_q.max_em_share       <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	tit_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.cluster_et  (cluster_et),
		.cluster_eta (cluster_eta),
		.cluster_phi (cluster_phi),
		.em_fraction (em_fraction),
		.last        (last),
		.qstat       (qstat),
		.push        (push),
		.push_entry  (push_entry)
	);

	tit_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	tit_back #(
		.SUM_BITS (SUM_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.qstat        (qstat),
		.pop          (pop),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.passed       (passed),
		.fail_reason  (fail_reason),
		.core_energy  (core_energy),
		.ring1_energy (ring1_energy),
		.ring2_energy (ring2_energy)
	);

endmodule

`default_nettype wire

FILE: rtl/tit_checker.sv
`default_nettype none

module tit_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        passed,
	input wire logic [tit_pkg::REASON_W-1:0] fail_reason,
	input wire logic [tit_pkg::OUT_W-1:0]   core_energy,
	input wire logic [tit_pkg::OUT_W-1:0]   ring1_energy,
	input wire logic [tit_pkg::OUT_W-1:0]   ring2_energy
);
	import tit_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(passed) && $stable(fail_reason)
			&& $stable(core_energy) && $stable(ring1_energy) && $stable(ring2_energy))
		else $error("result changed while stalled");

	a_pass_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (passed == (fail_reason == REASON_PASS)))
		else $error("pass flag disagrees with reason code");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fail_reason <= REASON_EM))
		else $error("reason code out of range");

	// With no energy in any ring the ratio cuts must not fire.
	a_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && core_energy == '0 && ring1_energy == '0 && ring2_energy == '0
			|-> fail_reason != REASON_CORE && fail_reason != REASON_RING1
				&& fail_reason != REASON_RING2)
		else $error("ratio cut fired on zero total");

endmodule

bind tau_isolation_trigger_top tit_checker u_checker (.*);

`default_nettype wire
